@@ sv/fhm_pkg.sv @@
// Package for the lock unit with FIFO handoff: request and response transfer
// types, operation, status and error codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fhm_pkg;

    localparam int ID_W = 6;

    // operation codes (code 3 acts as trylock)
    localparam logic [1:0] FN_LOCK    = 2'd0;
    localparam logic [1:0] FN_UNLOCK  = 2'd1;
    localparam logic [1:0] FN_TRYLOCK = 2'd2;
    localparam logic [1:0] FN_TRY_ALT = 2'd3;

    localparam logic [2:0] ST_ACQUIRED   = 3'd0;
    localparam logic [2:0] ST_REACQUIRED = 3'd1;
    localparam logic [2:0] ST_QUEUED     = 3'd2;
    localparam logic [2:0] ST_BUSY       = 3'd3;
    localparam logic [2:0] ST_RELEASED   = 3'd4;
    localparam logic [2:0] ST_HANDOFF    = 3'd5;
    localparam logic [2:0] ST_ERROR      = 3'd6;

    localparam logic [1:0] EK_NONE        = 2'd0;
    localparam logic [1:0] EK_UNLOCK_FREE = 2'd1;
    localparam logic [1:0] EK_NOT_OWNER   = 2'd2;
    localparam logic [1:0] EK_FULL        = 2'd3;

    typedef struct packed {
        logic [1:0]      func;
        logic [ID_W-1:0] requester_id;
    } t_req;

    typedef struct packed {
        logic [2:0]      status;
        logic [1:0]      error_kind;
        logic [ID_W-1:0] new_owner_id;
        logic            owner_valid;
        logic [6:0]      waiting_count;
    } t_rsp;

endpackage

`default_nettype wire

@@ sv/fifo_handoff_mutex_unit.sv @@
// Top level of the lock unit: owner register, FIFO of waiting requesters,
// one response per request. Depends on fhm_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Hardware lock with a FIFO wait queue. Each request (lock, unlock, trylock)
// transfers in when start is high and busy is low; busy is always low, so a
// request may be issued every clock cycle. Exactly one response comes back
// for each transfer, through the input register and then the response
// register, shown on o_rsp for a single cycle with o_valid high. The
// receiver cannot stall: it must take o_rsp in that cycle. Sustained rate
// is one request per cycle; the owner compare and a single push or pop of
// the wait queue memory happen together because the entry at the queue
// head is kept prefetched in a register. Unlock by the owner hands the lock
// to the head waiter (status handed off, new_owner_id is the requester to
// resume), or frees it when nobody waits. Bad unlocks and a lock against a
// full queue report status error with an error kind and leave the state
// alone. A requester must not be queued twice. The queue memory is not
// cleared at reset; only written entries are ever used.
module fifo_handoff_mutex_unit #(
    parameter int MAX_REQUESTERS = 64,
    parameter int QUEUE_DEPTH    = 64
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  fhm_pkg::t_req      i_req,
    output logic               o_valid,
    output fhm_pkg::t_rsp      o_rsp
);
    import fhm_pkg::*;

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // ---------------- input register ----------------
    logic            r_in_vld;
    t_req            r_in;

    // ---------------- lock state ----------------
    logic            r_held;
    logic [ID_W-1:0] r_owner;
    logic [QW-1:0]   r_head;
    logic [QW-1:0]   r_tail;
    logic [CW-1:0]   r_count;

    logic            n_held;
    logic [ID_W-1:0] n_owner;
    logic [QW-1:0]   n_head;
    logic [QW-1:0]   n_tail;
    logic [CW-1:0]   n_count;

    // wait queue memory and prefetched head entry
    logic [ID_W-1:0] r_mem [0:QUEUE_DEPTH-1];
    logic [ID_W-1:0] r_rd_data;
    logic            r_fwd;
    logic [ID_W-1:0] r_fwd_data;
    logic [ID_W-1:0] head_data;

    logic            push;
    logic            pop;
    logic [ID_W-1:0] id_mod [0:(1<<ID_W)-1];
    logic [ID_W-1:0] req_id;
    logic [2:0]      status;
    logic [1:0]      err;
    logic [CW+6:0]   count_ext;

    // ---------------- response register ----------------
    logic            r_out_vld;
    t_rsp            r_rsp;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
        r_in <= i_req;
    end

    // requester ID reduced modulo MAX_REQUESTERS: constant lookup table
    // over every value of the ID field
    for (genvar k = 0; k < (1 << ID_W); k++) begin : g_id_mod
        assign id_mod[k] = ID_W'(k % MAX_REQUESTERS);
    end

    assign req_id = id_mod[r_in.requester_id];

    assign head_data = r_fwd ? r_fwd_data : r_rd_data;

    function automatic logic [QW-1:0] next_slot(input logic [QW-1:0] p);
        logic [QW-1:0] q;
        if (p == QW'(QUEUE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    always_comb begin
        n_held  = r_held;
        n_owner = r_owner;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        push    = 1'b0;
        pop     = 1'b0;
        status  = ST_BUSY;
        err     = EK_NONE;
        if (r_in_vld) begin
            unique case (r_in.func)
                FN_LOCK: begin
                    if (!r_held) begin
                        n_held  = 1'b1;
                        n_owner = req_id;
                        status  = ST_ACQUIRED;
                    end else if (r_owner == req_id) begin
                        status = ST_REACQUIRED;
                    end else if (r_count == CW'(QUEUE_DEPTH)) begin
                        status = ST_ERROR;
                        err    = EK_FULL;
                    end else begin
                        push    = 1'b1;
                        n_tail  = next_slot(r_tail);
                        n_count = r_count + 1'b1;
                        status  = ST_QUEUED;
                    end
                end
                FN_UNLOCK: begin
                    if (!r_held) begin
                        status = ST_ERROR;
                        err    = EK_UNLOCK_FREE;
                    end else if (r_owner != req_id) begin
                        status = ST_ERROR;
                        err    = EK_NOT_OWNER;
                    end else if (r_count == '0) begin
                        n_held  = 1'b0;
                        n_owner = '0;
                        status  = ST_RELEASED;
                    end else begin
                        pop     = 1'b1;
                        n_owner = head_data;
                        n_head  = next_slot(r_head);
                        n_count = r_count - 1'b1;
                        status  = ST_HANDOFF;
                    end
                end
                default: begin
                    // trylock, also the unused code
                    if (!r_held) begin
                        n_held  = 1'b1;
                        n_owner = req_id;
                        status  = ST_ACQUIRED;
                    end else if (r_owner == req_id) begin
                        status = ST_REACQUIRED;
                    end else begin
                        status = ST_BUSY;
                    end
                end
            endcase
        end
    end

    assign count_ext = {7'b0, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= 1'b0;
            r_owner   <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            r_held    <= n_held;
            r_owner   <= n_owner;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_out_vld <= r_in_vld;
            // a push into the slot that becomes the head bypasses the memory
            r_fwd     <= push && (r_tail == n_head);
        end
        r_fwd_data          <= req_id;
        r_rsp.status        <= status;
        r_rsp.error_kind    <= err;
        r_rsp.new_owner_id  <= n_held ? n_owner : '0;
        r_rsp.owner_valid   <= n_held;
        r_rsp.waiting_count <= count_ext[6:0];
    end

    // queue memory: one write, one registered read of the next head slot
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_tail] <= req_id;
        end
        r_rd_data <= r_mem[n_head];
    end

    assign o_valid = r_out_vld;
    assign o_rsp   = r_rsp;

    // ---------------- assertions ----------------
    a_resp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("request transfer without response two cycles later");

    a_free_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_held |-> (r_count == '0))
        else $error("waiters queued while the lock is free");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_count != '0) && r_held)
        else $error("handoff from an empty queue");

    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status == ST_ERROR)) |-> (o_rsp.error_kind != EK_NONE))
        else $error("error status without error kind");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Testbench for the lock unit with FIFO handoff: directed and random request
// streams checked against an in-bench model of owner and wait queue.
// Depends on fhm_pkg and fifo_handoff_mutex_unit.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import fhm_pkg::*;

    localparam int QDEPTH      = 64;
    localparam int STALL_LIMIT = 2000;   // cycles with no transfer either way
    localparam int TAIL_CYCLES = 4;      // idle cycles after the final drain
    localparam int PRINT_LIMIT = 100;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_req  i_req;
    logic  o_valid;
    t_rsp  o_rsp;

    fifo_handoff_mutex_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // ---------------------------------------------------------------
    // Lock model: owner register plus circular wait queue. Advanced once
    // per accepted request, in transfer order.
    // ---------------------------------------------------------------
    logic            lock_held  = 1'b0;
    logic [ID_W-1:0] lock_owner = '0;
    logic [ID_W-1:0] waiters [QDEPTH];
    int              wait_head  = 0;
    int              wait_tail  = 0;
    int              wait_count = 0;

    t_rsp rsp_expected [$];
    int   err_count  = 0;
    int   result_idx = 0;
    int   idle_pct   = 37;    // chance in 100 that the sender idles a cycle

    function automatic t_rsp lock_predict(input t_req r);
        t_rsp            p;
        logic [ID_W-1:0] rid;
        p   = '0;
        rid = r.requester_id;   // ID space equals the field width here
        p.error_kind = EK_NONE;
        if (r.func == FN_TRYLOCK || r.func == FN_TRY_ALT) begin
            if (!lock_held) begin
                lock_held  = 1'b1;
                lock_owner = rid;
                p.status   = ST_ACQUIRED;
            end else if (lock_owner == rid) begin
                p.status = ST_REACQUIRED;
            end else begin
                p.status = ST_BUSY;
            end
        end else if (r.func == FN_UNLOCK) begin
            if (!lock_held) begin
                p.status     = ST_ERROR;
                p.error_kind = EK_UNLOCK_FREE;
            end else if (lock_owner != rid) begin
                p.status     = ST_ERROR;
                p.error_kind = EK_NOT_OWNER;
            end else if (wait_count == 0) begin
                lock_held  = 1'b0;
                lock_owner = '0;
                p.status   = ST_RELEASED;
            end else begin
                // pass ownership to the oldest waiter
                lock_owner = waiters[wait_head];
                wait_head  = (wait_head + 1) % QDEPTH;
                wait_count = wait_count - 1;
                p.status   = ST_HANDOFF;
            end
        end else begin
            if (!lock_held) begin
                lock_held  = 1'b1;
                lock_owner = rid;
                p.status   = ST_ACQUIRED;
            end else if (lock_owner == rid) begin
                p.status = ST_REACQUIRED;
            end else if (wait_count >= QDEPTH) begin
                p.status     = ST_ERROR;
                p.error_kind = EK_FULL;
            end else begin
                waiters[wait_tail] = rid;
                wait_tail  = (wait_tail + 1) % QDEPTH;
                wait_count = wait_count + 1;
                p.status   = ST_QUEUED;
            end
        end
        p.new_owner_id  = lock_held ? lock_owner : '0;
        p.owner_valid   = lock_held;
        p.waiting_count = 7'(wait_count);
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // ---------------------------------------------------------------
    // Clock and reset
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Response checker. Outputs are registered, so values read at the
    // edge are the ones of the cycle that just ended.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && o_valid) begin
            if (rsp_expected.size() == 0) begin
                report_mismatch($sformatf("response with none pending: %p", o_rsp));
            end else begin
                exp_rsp = rsp_expected.pop_front();
                if (o_rsp.status !== exp_rsp.status)
                    report_mismatch($sformatf("rsp %0d status %0d, want %0d",
                        result_idx, o_rsp.status, exp_rsp.status));
                if (o_rsp.error_kind !== exp_rsp.error_kind)
                    report_mismatch($sformatf("rsp %0d error_kind %0d, want %0d",
                        result_idx, o_rsp.error_kind, exp_rsp.error_kind));
                if (o_rsp.new_owner_id !== exp_rsp.new_owner_id)
                    report_mismatch($sformatf("rsp %0d new_owner_id %0d, want %0d",
                        result_idx, o_rsp.new_owner_id, exp_rsp.new_owner_id));
                if (o_rsp.owner_valid !== exp_rsp.owner_valid)
                    report_mismatch($sformatf("rsp %0d owner_valid %0d, want %0d",
                        result_idx, o_rsp.owner_valid, exp_rsp.owner_valid));
                if (o_rsp.waiting_count !== exp_rsp.waiting_count)
                    report_mismatch($sformatf("rsp %0d waiting_count %0d, want %0d",
                        result_idx, o_rsp.waiting_count, exp_rsp.waiting_count));
            end
            result_idx++;
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: any cycle without a request or response transfer counts.
    // ---------------------------------------------------------------
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_valid)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Request driver. Optional idle cycles first, then hold the request
    // until the transfer edge; the model advances right at that edge.
    // ---------------------------------------------------------------
    task automatic send_req(input logic [1:0] fn, input logic [ID_W-1:0] id);
        t_req r;
        r.func         = fn;
        r.requester_id = id;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        rsp_expected.push_back(lock_predict(r));
    endtask

    // Hold requests off until every pending response is back.
    task automatic drain_responses();
        start <= 1'b0;
        while (rsp_expected.size() != 0) @(posedge i_clk);
    endtask

    // Every operation, ID extremes, bad unlocks, duplicate waiter, alias code.
    task automatic test_directed();
        send_req(FN_UNLOCK,  6'd5);    // unlock when free
        send_req(FN_LOCK,    6'd0);    // acquire
        send_req(FN_LOCK,    6'd0);    // owner again
        send_req(FN_TRYLOCK, 6'd0);    // owner trylock
        send_req(FN_TRYLOCK, 6'd63);   // busy
        send_req(FN_TRY_ALT, 6'd63);   // unused code acts as trylock
        send_req(FN_UNLOCK,  6'd63);   // unlock by non-owner
        send_req(FN_LOCK,    6'd63);   // queued
        send_req(FN_LOCK,    6'd42);   // queued
        send_req(FN_LOCK,    6'd63);   // duplicate waiter
        send_req(FN_UNLOCK,  6'd0);    // handoff to 63
        send_req(FN_UNLOCK,  6'd63);   // handoff to 42
        send_req(FN_TRY_ALT, 6'd42);   // owner via alias code
        send_req(FN_UNLOCK,  6'd42);   // handoff to 63 again
        send_req(FN_UNLOCK,  6'd63);   // released
        send_req(FN_UNLOCK,  6'd63);   // unlock when free
        send_req(FN_TRY_ALT, 6'd21);   // acquire via alias code
        send_req(FN_LOCK,    6'd42);
        send_req(FN_UNLOCK,  6'd42);   // non-owner
        send_req(FN_UNLOCK,  6'd21);
        send_req(FN_TRYLOCK, 6'd21);   // busy, 42 owns it
        send_req(FN_UNLOCK,  6'd42);
        send_req(FN_TRYLOCK, 6'd63);
        send_req(FN_UNLOCK,  6'd63);
    endtask

    // Fill the wait queue to its depth, overflow it, then drain it through
    // handoffs so both pointers wrap.
    task automatic test_queue_full();
        logic [ID_W-1:0] id;
        send_req(FN_LOCK, 6'd1);
        for (int i = 0; i < QDEPTH; i++) begin
            id = ID_W'($urandom_range(63));
            if (id == 6'd1) id = 6'd0;
            send_req(FN_LOCK, id);
        end
        send_req(FN_LOCK, 6'd7);       // queue full
        send_req(FN_TRYLOCK, 6'd9);    // busy, full queue untouched
        for (int i = 0; i <= QDEPTH; i++)
            send_req(FN_UNLOCK, lock_owner);
    endtask

    // Random stream. The lock weight changes per burst so the queue both
    // empties often and sometimes climbs to full; most unlocks come from
    // the owner so handoff chains run deep.
    task automatic test_random(input int n_items, input int pct);
        int              lock_w;
        int              r;
        logic [1:0]      fn;
        logic [ID_W-1:0] id;
        idle_pct = pct;
        lock_w   = 45;
        for (int n = 0; n < n_items; n++) begin
            if (n % 80 == 0) lock_w = $urandom_range(65, 25);
            r  = $urandom_range(99);
            id = ID_W'($urandom_range(63));
            if (r < lock_w) begin
                fn = FN_LOCK;
                if (lock_held && $urandom_range(99) < 10) id = lock_owner;
            end else if (r < lock_w + 30) begin
                fn = FN_UNLOCK;
                if (lock_held && $urandom_range(99) < 80) id = lock_owner;
            end else begin
                fn = $urandom_range(1) ? FN_TRYLOCK : FN_TRY_ALT;
                if (lock_held && $urandom_range(99) < 30) id = lock_owner;
            end
            send_req(fn, id);
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_req   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct = 37;
        test_directed();
        test_queue_full();
        test_random(500, 37);
        drain_responses();
        test_random(500, 69);
        drain_responses();
        test_random(500, 0);

        drain_responses();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (rsp_expected.size() != 0)
            report_mismatch($sformatf("%0d responses never came", rsp_expected.size()));

        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
